// ===== rtl/core/vsm_pkg.sv =====
// vsm_pkg: shared types, codes and constants for the vswr meter and trip block
// used by every module under rtl/core; no dependencies of its own

package vsm_pkg;

   // port widths
   localparam int REQ_DATA_W  = 32;
   localparam int REQ_USER_W  = 3;
   localparam int RSP_DATA_W  = 88;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 32;

   // field widths
   localparam int RAW_W   = 16;
   localparam int MAG_W   = 48;
   localparam int ACC_W   = 96;
   localparam int POWER_W = 32;
   localparam int VSWR_W  = 16;
   localparam int TICK_W  = 16;
   localparam int HALF_W  = 24;

   // divider: dividend is the 16-bit sum shifted up by 8
   localparam int DIV_STEPS = 24;
   localparam int DIV_CNT_W = 5;

   // work queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   // request mode codes
   localparam logic [REQ_USER_W-1:0] MODE_SAMPLE  = 3'd0;
   localparam logic [REQ_USER_W-1:0] MODE_TICK    = 3'd1;
   localparam logic [REQ_USER_W-1:0] MODE_RELEASE = 3'd2;
   localparam logic [REQ_USER_W-1:0] MODE_DISARM  = 3'd3;
   localparam logic [REQ_USER_W-1:0] MODE_ARM     = 3'd4;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_VOLT_SCALE      = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FWD_POWER_MAX   = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_REV_POWER_MAX   = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_FWD_POWER_MIN   = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_REV_POWER_FLOOR = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_VSWR_LIMIT      = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_COOLDOWN_TICKS  = 3'd6;

   // register reset values
   localparam logic [31:0] RST_VOLT_SCALE      = 32'd105041;
   localparam logic [31:0] RST_FWD_POWER_MAX   = 32'd838860800;
   localparam logic [31:0] RST_REV_POWER_MAX   = 32'd16777216;
   localparam logic [31:0] RST_FWD_POWER_MIN   = 32'd16777;
   localparam logic [31:0] RST_REV_POWER_FLOOR = 32'd1677722;
   localparam logic [15:0] RST_VSWR_LIMIT      = 16'd384;
   localparam logic [15:0] RST_COOLDOWN_TICKS  = 16'd2000;

   // vswr special values, Q8.8
   localparam logic [VSWR_W-1:0] VSWR_ONE  = 16'd256;
   localparam logic [VSWR_W-1:0] VSWR_SAT  = 16'hFFFF;
   localparam logic [VSWR_W-1:0] VSWR_ZERO = 16'd0;

   // classified work kinds
   typedef enum logic [2:0] {
      OP_NOP,
      OP_SAMPLE,
      OP_TICK,
      OP_RELEASE,
      OP_DISARM,
      OP_ARM
   } op_type;

   // one queued word
   typedef struct packed {
      op_type                  op;
      logic signed [RAW_W-1:0] fwd_raw;
      logic signed [RAW_W-1:0] rev_raw;
   } work_type;

   // configuration registers
   typedef struct packed {
      logic [31:0]       volt_scale;
      logic [POWER_W-1:0] fwd_power_max;
      logic [POWER_W-1:0] rev_power_max;
      logic [POWER_W-1:0] fwd_power_min;
      logic [POWER_W-1:0] rev_power_floor;
      logic [VSWR_W-1:0]  vswr_limit;
      logic [TICK_W-1:0]  cooldown_ticks;
   } cfg_type;

endpackage

// ===== rtl/core/vswr_measure_and_trip.sv =====
// vswr_measure_and_trip: top level, configuration registers plus front and back
// instantiates vsm_front and vsm_back; uses vsm_pkg
//
// Each request word carries a mode in req_tuser and, for a sample, the signed
// forward and reverse detector counts in req_tdata. Every request word gives
// exactly one response word: forward and reverse power (Q8.24 watts), VSWR
// (Q8.8), key, auto-release and cooling flags in rsp_tdata, and in rsp_tuser
// a flag set when the word was a sample that was measured and checked.
// The front takes requests into a two-word queue; the back executes them in
// order and owns the response register, so a stalled response does not stop
// intake until the queue fills.
// Timing: tick, release, arm, disarm, unused modes and samples ignored during
// cooldown go from the queue head straight to the response register. A
// measured sample waits for the 24-step serial divider for the VSWR ratio;
// the two power units finish within it. Throughput is one word a cycle while
// responses are taken; no new word starts until a measured sample is answered.
// Reset (synchronous, active high) loads the register defaults, enables the
// key and auto-release, clears cooldown and the powers and sets VSWR to 1.0.
// While rsp_tready is low the response holds and the back waits for it.
// Registers are written through csr_we/csr_index/csr_wdata only while the block is idle: a user rule, not enforced.

module vswr_measure_and_trip (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [vsm_pkg::REQ_DATA_W-1:0]   req_tdata,   // fwd_raw, rev_raw
   input  logic [vsm_pkg::REQ_USER_W-1:0]   req_tuser,   // mode
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // fwd_power, rev_power, vswr_value, key_enabled, auto_release, cooling, zero pad
   output logic [vsm_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   output logic                             rsp_tuser,   // evaluated
   input  logic                             csr_we,
   input  logic [vsm_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [vsm_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import vsm_pkg::*;

   cfg_type  cfg_ff, cfg_in;
   logic     work_valid;
   logic     work_pop;
   work_type work;

   // configuration register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_VOLT_SCALE:      cfg_in.volt_scale      = csr_wdata;
            CSR_FWD_POWER_MAX:   cfg_in.fwd_power_max   = csr_wdata;
            CSR_REV_POWER_MAX:   cfg_in.rev_power_max   = csr_wdata;
            CSR_FWD_POWER_MIN:   cfg_in.fwd_power_min   = csr_wdata;
            CSR_REV_POWER_FLOOR: cfg_in.rev_power_floor = csr_wdata;
            CSR_VSWR_LIMIT:      cfg_in.vswr_limit      = csr_wdata[VSWR_W-1:0];
            CSR_COOLDOWN_TICKS:  cfg_in.cooldown_ticks  = csr_wdata[TICK_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.volt_scale      <= RST_VOLT_SCALE;
         cfg_ff.fwd_power_max   <= RST_FWD_POWER_MAX;
         cfg_ff.rev_power_max   <= RST_REV_POWER_MAX;
         cfg_ff.fwd_power_min   <= RST_FWD_POWER_MIN;
         cfg_ff.rev_power_floor <= RST_REV_POWER_FLOOR;
         cfg_ff.vswr_limit      <= RST_VSWR_LIMIT;
         cfg_ff.cooldown_ticks  <= RST_COOLDOWN_TICKS;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   vsm_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .work_valid (work_valid),
      .work_pop   (work_pop),
      .work       (work)
   );

   vsm_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .work_valid (work_valid),
      .work_pop   (work_pop),
      .work       (work),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

// ===== rtl/core/vsm_power.sv =====
// vsm_power: power unit, 50*(mag*scale)^2 as Q8.24 watts, saturated
// one shared 24x24 multiplier over the partial products; uses vsm_pkg

module vsm_power (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [vsm_pkg::RAW_W-1:0]    mag,
   input  logic [31:0]                  scale,
   output logic                         busy,
   output logic [vsm_pkg::POWER_W-1:0]  power
);
   import vsm_pkg::*;

   // step codes
   localparam logic [2:0] PW_IDLE  = 3'd0;
   localparam logic [2:0] PW_LOW   = 3'd1;
   localparam logic [2:0] PW_CROSS = 3'd2;
   localparam logic [2:0] PW_HIGH  = 3'd3;
   localparam logic [2:0] PW_FINAL = 3'd4;

   logic [2:0]         step_ff, step_in;
   logic               busy_ff, busy_in;
   logic [MAG_W-1:0]   m_ff, m_in;
   logic [ACC_W-1:0]   acc_ff, acc_in;
   logic [POWER_W-1:0] power_ff, power_in;

   logic [HALF_W-1:0]   op_a, op_b;
   logic [2*HALF_W-1:0] prod;
   logic [ACC_W-1:0]    addend;
   logic [ACC_W+4:0]    wide;

   // operand select for the shared multiplier
   always_comb begin
      unique case (step_ff)
         PW_LOW: begin
            op_a   = m_ff[HALF_W-1:0];
            op_b   = m_ff[HALF_W-1:0];
         end
         PW_CROSS: begin
            op_a   = m_ff[MAG_W-1:HALF_W];
            op_b   = m_ff[HALF_W-1:0];
         end
         default: begin
            op_a   = m_ff[MAG_W-1:HALF_W];
            op_b   = m_ff[MAG_W-1:HALF_W];
         end
      endcase
      prod = op_a * op_b;
   end

   // partial product placement, cross term counted twice
   always_comb begin
      unique case (step_ff)
         PW_LOW:   addend = {{(ACC_W-2*HALF_W){1'b0}}, prod};
         PW_CROSS: addend = {{(ACC_W-3*HALF_W-1){1'b0}}, prod, {(HALF_W+1){1'b0}}};
         default:  addend = {prod, {(2*HALF_W){1'b0}}};
      endcase
   end

   // times 50 as 32 + 16 + 2, then saturate at 2^72
   assign wide = {acc_ff, 5'b0} + {1'b0, acc_ff, 4'b0} + {4'b0, acc_ff, 1'b0};

   // sequencer
   always_comb begin
      step_in  = step_ff;
      busy_in  = busy_ff;
      m_in     = m_ff;
      acc_in   = acc_ff;
      power_in = power_ff;
      unique case (step_ff)
         PW_IDLE: begin
            if (start) begin
               m_in    = mag * scale;
               acc_in  = '0;
               busy_in = 1'b1;
               step_in = PW_LOW;
            end
         end
         PW_LOW, PW_CROSS, PW_HIGH: begin
            acc_in  = acc_ff + addend;
            step_in = step_ff + 3'd1;
         end
         PW_FINAL: begin
            power_in = (|wide[ACC_W+4:72]) ? '1 : wide[71:40];
            busy_in  = 1'b0;
            step_in  = PW_IDLE;
         end
         default: begin
            busy_in = 1'b0;
            step_in = PW_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= PW_IDLE;
         busy_ff <= 1'b0;
      end else begin
         step_ff <= step_in;
         busy_ff <= busy_in;
      end
      m_ff     <= m_in;
      acc_ff   <= acc_in;
      power_ff <= power_in;
   end

   assign busy  = busy_ff;
   assign power = power_ff;

endmodule

// ===== rtl/core/vsm_div.sv =====
// vsm_div: restoring divider for the vswr ratio, one quotient bit a cycle
// quotient saturated to 16 bits; uses vsm_pkg

module vsm_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [vsm_pkg::HALF_W-1:0]  dividend,
   input  logic [vsm_pkg::VSWR_W-1:0]  divisor,
   output logic                        busy,
   output logic [vsm_pkg::VSWR_W-1:0]  quotient
);
   import vsm_pkg::*;

   logic                 busy_ff, busy_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [HALF_W-1:0]    quo_ff, quo_in;
   logic [VSWR_W-1:0]    rem_ff, rem_in;
   logic [VSWR_W-1:0]    dvs_ff, dvs_in;

   logic [VSWR_W:0] trial;
   logic [VSWR_W:0] diff;
   logic            ge;

   // trial subtract of the next dividend bit
   assign trial = {rem_ff, quo_ff[HALF_W-1]};
   assign diff  = trial - {1'b0, dvs_ff};
   assign ge    = trial >= {1'b0, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (busy_ff) begin
         quo_in = {quo_ff[HALF_W-2:0], ge};
         rem_in = ge ? diff[VSWR_W-1:0] : trial[VSWR_W-1:0];
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
            busy_in = 1'b0;
         end
      end else if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign busy     = busy_ff;
   assign quotient = (|quo_ff[HALF_W-1:VSWR_W]) ? VSWR_SAT : quo_ff[VSWR_W-1:0];

endmodule

// ===== rtl/core/vsm_front.sv =====
// vsm_front: request intake, mode decode and a short work queue
// feeds classified words to vsm_back; uses vsm_pkg

module vsm_front (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [vsm_pkg::REQ_DATA_W-1:0]  req_tdata,   // fwd_raw, rev_raw
   input  logic [vsm_pkg::REQ_USER_W-1:0]  req_tuser,   // mode
   output logic                            work_valid,
   input  logic                            work_pop,
   output vsm_pkg::work_type               work
);
   import vsm_pkg::*;

   work_type               q_mem [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;

   work_type entry;
   logic     push;
   logic     pop;

   // classify the mode
   always_comb begin
      unique case (req_tuser)
         MODE_SAMPLE:  entry.op = OP_SAMPLE;
         MODE_TICK:    entry.op = OP_TICK;
         MODE_RELEASE: entry.op = OP_RELEASE;
         MODE_DISARM:  entry.op = OP_DISARM;
         MODE_ARM:     entry.op = OP_ARM;
         default:      entry.op = OP_NOP;
      endcase
      entry.fwd_raw = req_tdata[RAW_W-1:0];
      entry.rev_raw = req_tdata[2*RAW_W-1:RAW_W];
   end

   assign req_tready = count_ff != QUEUE_CNT_W'(QUEUE_DEPTH);
   assign push       = req_tvalid && req_tready;
   assign work_valid = count_ff != '0;
   assign pop        = work_pop && work_valid;
   assign work       = q_mem[rd_ptr_ff];

   // queue pointers
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         q_mem[wr_ptr_ff] <= entry;
      end
   end

endmodule

// ===== rtl/core/vsm_back.sv =====
// vsm_back: executes queued words, keeps trip state and the result register
// instantiates vsm_power twice and vsm_div; uses vsm_pkg

module vsm_back (
   input  logic                            clock,
   input  logic                            reset,
   input  vsm_pkg::cfg_type                cfg,
   input  logic                            work_valid,
   output logic                            work_pop,
   input  vsm_pkg::work_type               work,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [vsm_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   output logic                            rsp_tuser
);
   import vsm_pkg::*;

   // sequencer states
   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_RUN  = 1'b1;

   logic               state_ff, state_in;
   logic               key_on_ff, key_on_in;
   logic               auto_ff, auto_in;
   logic [TICK_W-1:0]  cooldown_ff, cooldown_in;
   logic [POWER_W-1:0] fwd_pw_ff, fwd_pw_in;
   logic [POWER_W-1:0] rev_pw_ff, rev_pw_in;
   logic [VSWR_W-1:0]  vswr_ff, vswr_in;
   logic               s_pos_ff, s_pos_in;
   logic               d_pos_ff, d_pos_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic               rsp_user_ff, rsp_user_in;

   logic [RAW_W:0]     sum, dif;
   logic [RAW_W-1:0]   fwd_mag, rev_mag;
   logic               start;
   logic               fwd_busy, rev_busy, div_busy;
   logic [POWER_W-1:0] fwd_power, rev_power;
   logic [VSWR_W-1:0]  quotient;
   logic               out_free;
   logic               units_idle;
   logic               emit;
   logic               evaluated;
   logic [VSWR_W-1:0]  vswr_sel;
   logic               trip;

   // sum and difference of the raw counts; the scale cancels in the ratio
   assign sum     = {work.fwd_raw[RAW_W-1], work.fwd_raw} + {work.rev_raw[RAW_W-1], work.rev_raw};
   assign dif     = {work.fwd_raw[RAW_W-1], work.fwd_raw} - {work.rev_raw[RAW_W-1], work.rev_raw};
   assign fwd_mag = work.fwd_raw[RAW_W-1] ? RAW_W'(~work.fwd_raw + 1'b1) : work.fwd_raw;
   assign rev_mag = work.rev_raw[RAW_W-1] ? RAW_W'(~work.rev_raw + 1'b1) : work.rev_raw;

   vsm_power u_fwd_power (
      .clock (clock),
      .reset (reset),
      .start (start),
      .mag   (fwd_mag),
      .scale (cfg.volt_scale),
      .busy  (fwd_busy),
      .power (fwd_power)
   );

   vsm_power u_rev_power (
      .clock (clock),
      .reset (reset),
      .start (start),
      .mag   (rev_mag),
      .scale (cfg.volt_scale),
      .busy  (rev_busy),
      .power (rev_power)
   );

   vsm_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .dividend ({sum[VSWR_W-1:0], 8'b0}),
      .divisor  (dif[VSWR_W-1:0]),
      .busy     (div_busy),
      .quotient (quotient)
   );

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign units_idle = !fwd_busy && !rev_busy && !div_busy;

   // vswr selection, low forward power first
   always_comb begin
      priority if (fwd_power <= cfg.fwd_power_min) begin
         vswr_sel = VSWR_ONE;
      end else if (!d_pos_ff) begin
         vswr_sel = VSWR_SAT;
      end else if (!s_pos_ff) begin
         vswr_sel = VSWR_ZERO;
      end else begin
         vswr_sel = quotient;
      end
   end

   assign trip = (fwd_power > cfg.fwd_power_max) || (rev_power > cfg.rev_power_max) ||
                 ((vswr_sel > cfg.vswr_limit) && (rev_power > cfg.rev_power_floor));

   // sequencer and trip state
   always_comb begin
      state_in    = state_ff;
      key_on_in   = key_on_ff;
      auto_in     = auto_ff;
      cooldown_in = cooldown_ff;
      fwd_pw_in   = fwd_pw_ff;
      rev_pw_in   = rev_pw_ff;
      vswr_in     = vswr_ff;
      s_pos_in    = s_pos_ff;
      d_pos_in    = d_pos_ff;
      work_pop    = 1'b0;
      start       = 1'b0;
      emit        = 1'b0;
      evaluated   = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (work_valid && out_free) begin
               work_pop = 1'b1;
               emit     = 1'b1;
               unique case (work.op)
                  OP_SAMPLE: begin
                     if (cooldown_ff == '0) begin
                        start    = 1'b1;
                        emit     = 1'b0;
                        s_pos_in = !sum[RAW_W] && (|sum);
                        d_pos_in = !dif[RAW_W] && (|dif);
                        state_in = ST_RUN;
                     end
                  end
                  OP_TICK: begin
                     if (cooldown_ff != '0) begin
                        cooldown_in = cooldown_ff - 1'b1;
                     end
                  end
                  OP_RELEASE: key_on_in = 1'b1;
                  OP_DISARM: begin
                     auto_in   = 1'b0;
                     key_on_in = 1'b0;
                  end
                  OP_ARM:   auto_in = 1'b1;
                  default: ;
               endcase
            end
         end
         default: begin
            if (units_idle && out_free) begin
               emit      = 1'b1;
               evaluated = 1'b1;
               fwd_pw_in = fwd_power;
               rev_pw_in = rev_power;
               vswr_in   = vswr_sel;
               state_in  = ST_IDLE;
               if (trip) begin
                  key_on_in = 1'b0;
                  if (auto_ff) begin
                     cooldown_in = cfg.cooldown_ticks;
                  end
               end else if (!key_on_ff && auto_ff) begin
                  key_on_in = 1'b1;
               end
            end
         end
      endcase
   end

   // result register
   always_comb begin
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      rsp_valid_in = rsp_valid_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_user_in  = evaluated;
         rsp_data_in  = {5'b0, cooldown_in != '0, auto_in, key_on_in,
                         vswr_in, rev_pw_in, fwd_pw_in};
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         key_on_ff    <= 1'b1;
         auto_ff      <= 1'b1;
         cooldown_ff  <= '0;
         fwd_pw_ff    <= '0;
         rev_pw_ff    <= '0;
         vswr_ff      <= VSWR_ONE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         key_on_ff    <= key_on_in;
         auto_ff      <= auto_in;
         cooldown_ff  <= cooldown_in;
         fwd_pw_ff    <= fwd_pw_in;
         rev_pw_ff    <= rev_pw_in;
         vswr_ff      <= vswr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      s_pos_ff    <= s_pos_in;
      d_pos_ff    <= d_pos_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

// ===== tb/testbench.sv =====
// testbench: self-checking bench for the vswr meter and relay trip block
// depends on vsm_pkg and vswr_measure_and_trip; predicts every response word in-bench

`timescale 1ns / 1ps

module testbench;
   import vsm_pkg::*;

   localparam int STUCK_LIMIT = 4000;
   localparam int TAIL_CYCLES = 40;
   localparam int REPORT_MAX  = 10;

   // modes the block treats as no operation, and the register index it ignores
   localparam logic [REQ_USER_W-1:0]  MODE_UNUSED_LO = 3'd5;
   localparam logic [REQ_USER_W-1:0]  MODE_UNUSED_MID = 3'd6;
   localparam logic [REQ_USER_W-1:0]  MODE_UNUSED_HI = 3'd7;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE = 3'd7;

   // one response word split into its fields
   typedef struct packed {
      logic [POWER_W-1:0] fwd_power;
      logic [POWER_W-1:0] rev_power;
      logic [VSWR_W-1:0]  vswr_value;
      logic               key_enabled;
      logic               auto_release;
      logic               cooling;
      logic               evaluated;
   } reading_type;

   // one row of the directed table
   typedef struct packed {
      logic [REQ_USER_W-1:0] mode;
      logic [RAW_W-1:0]      fwd_cnt;
      logic [RAW_W-1:0]      rev_cnt;
      logic                  typed;
      reading_type           want;
   } plan_row_type;

   localparam reading_type AT_RESET    = '{32'd0, 32'd0, VSWR_ONE, 1'b1, 1'b1, 1'b0, 1'b0};
   localparam reading_type ZERO_SAMPLE = '{32'd0, 32'd0, VSWR_ONE, 1'b1, 1'b1, 1'b0, 1'b1};
   localparam reading_type NO_READING  = '0;

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_DATA_W-1:0]  req_tdata;   // fwd_raw, rev_raw
   logic [REQ_USER_W-1:0]  req_tuser;   // mode
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   // fwd_power, rev_power, vswr_value, key_enabled, auto_release, cooling, zero pad
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic                   rsp_tuser;   // evaluated
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   // meter state as the predictor sees it
   cfg_type            meter_cfg;
   logic               key_on;
   logic               auto_release_on;
   logic [TICK_W-1:0]  cooldown_left;
   logic [POWER_W-1:0] fwd_power_now;
   logic [POWER_W-1:0] rev_power_now;
   logic [VSWR_W-1:0]  vswr_now;

   reading_type expected_readings[$];
   int          mismatches = 0;
   int          stuck_cycles = 0;
   bit          calm = 1'b0;

   vswr_measure_and_trip i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // 50*v^2 in Q8.24 watts from a Q.32 volt magnitude, truncated, saturated
   function automatic logic [POWER_W-1:0] power_q824(input logic [MAG_W-1:0] mag);
      logic [127:0] prod;
      prod = {80'd0, mag} * {80'd0, mag} * 128'd50;
      return (prod[127:72] != '0) ? '1 : prod[71:40];
   endfunction

   // relay trip; a cooldown only starts while auto-release is on
   function automatic void trip_key();
      key_on = 1'b0;
      if (auto_release_on) cooldown_left = meter_cfg.cooldown_ticks;
   endfunction

   // advance the meter state by one request word and return its response
   function automatic reading_type predict_word(input logic [REQ_USER_W-1:0] mode,
                                                input logic signed [RAW_W-1:0] fwd_cnt,
                                                input logic signed [RAW_W-1:0] rev_cnt);
      reading_type        reading;
      logic               measured;
      logic signed [63:0] scale, fwd_v, rev_v, v_sum, v_diff;
      logic [63:0]        fwd_mag, rev_mag, quotient;
      measured = 1'b0;
      case (mode)
         MODE_SAMPLE: begin
            if (cooldown_left == '0) begin
               scale   = $signed({32'd0, meter_cfg.volt_scale});
               fwd_v   = fwd_cnt * scale;
               rev_v   = rev_cnt * scale;
               fwd_mag = (fwd_v < 0) ? -fwd_v : fwd_v;
               rev_mag = (rev_v < 0) ? -rev_v : rev_v;
               fwd_power_now = power_q824(fwd_mag[MAG_W-1:0]);
               rev_power_now = power_q824(rev_mag[MAG_W-1:0]);
               v_sum  = fwd_v + rev_v;
               v_diff = fwd_v - rev_v;
               // low forward power wins over both sign cases
               if (fwd_power_now <= meter_cfg.fwd_power_min) begin
                  vswr_now = VSWR_ONE;
               end else if (v_diff <= 0) begin
                  vswr_now = VSWR_SAT;
               end else if (v_sum <= 0) begin
                  vswr_now = VSWR_ZERO;
               end else begin
                  quotient = {v_sum[55:0], 8'd0} / v_diff;
                  vswr_now = (quotient > 64'hFFFF) ? VSWR_SAT : quotient[VSWR_W-1:0];
               end
               measured = 1'b1;
               if (fwd_power_now > meter_cfg.fwd_power_max ||
                   rev_power_now > meter_cfg.rev_power_max ||
                   (vswr_now > meter_cfg.vswr_limit &&
                    rev_power_now > meter_cfg.rev_power_floor)) begin
                  trip_key();
               end else if (!key_on && auto_release_on) begin
                  key_on = 1'b1;
               end
            end
         end
         MODE_TICK: begin
            if (cooldown_left != '0) cooldown_left = cooldown_left - 1'b1;
         end
         MODE_RELEASE: key_on = 1'b1;
         MODE_DISARM: begin
            auto_release_on = 1'b0;
            trip_key();
         end
         MODE_ARM: auto_release_on = 1'b1;
         default: ;
      endcase
      reading.fwd_power    = fwd_power_now;
      reading.rev_power    = rev_power_now;
      reading.vswr_value   = vswr_now;
      reading.key_enabled  = key_on;
      reading.auto_release = auto_release_on;
      reading.cooling      = (cooldown_left != '0);
      reading.evaluated    = measured;
      return reading;
   endfunction

   // sample counts: mostly plausible forward/reflected pairs, some raw noise
   function automatic void draw_counts(output logic [RAW_W-1:0] fwd_cnt,
                                       output logic [RAW_W-1:0] rev_cnt);
      logic [RAW_W-1:0] rails [6];
      rails = '{16'h8000, 16'h8001, 16'hFFFF, 16'h0000, 16'h0001, 16'h7FFF};
      case ($urandom_range(9))
         0, 1, 2, 3: begin
            fwd_cnt = 16'($urandom_range(32767) >> $urandom_range(8));
            rev_cnt = fwd_cnt >> $urandom_range(6, 1);
            if ($urandom_range(3) == 0) rev_cnt = -rev_cnt;
         end
         4, 5: begin
            fwd_cnt = 16'($urandom_range(32767));
            rev_cnt = fwd_cnt - 16'($urandom_range(3));
         end
         6: begin
            fwd_cnt = rails[$urandom_range(5)];
            rev_cnt = rails[$urandom_range(5)];
         end
         7: begin
            fwd_cnt = -16'($urandom_range(32768) >> $urandom_range(8));
            rev_cnt = 16'($urandom_range(4095)) - 16'd2048;
         end
         default: begin
            fwd_cnt = 16'($urandom);
            rev_cnt = 16'($urandom);
         end
      endcase
   endfunction

   task automatic note_mismatch(input string what);
      mismatches++;
      if (mismatches <= REPORT_MAX) $display("mismatch at %0t: %s", $time, what);
   endtask

   // one register write per clock; the caller lowers csr_we after the last one
   task automatic write_reg(input logic [CSR_INDEX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      case (index)
         CSR_VOLT_SCALE:      meter_cfg.volt_scale      = value;
         CSR_FWD_POWER_MAX:   meter_cfg.fwd_power_max   = value;
         CSR_REV_POWER_MAX:   meter_cfg.rev_power_max   = value;
         CSR_FWD_POWER_MIN:   meter_cfg.fwd_power_min   = value;
         CSR_REV_POWER_FLOOR: meter_cfg.rev_power_floor = value;
         CSR_VSWR_LIMIT:      meter_cfg.vswr_limit      = value[VSWR_W-1:0];
         CSR_COOLDOWN_TICKS:  meter_cfg.cooldown_ticks  = value[TICK_W-1:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   // offer one request word, wait for its handshake, then queue the prediction
   task automatic send_word(input logic [REQ_USER_W-1:0] mode,
                            input logic [RAW_W-1:0] fwd_cnt,
                            input logic [RAW_W-1:0] rev_cnt,
                            input logic typed,
                            input reading_type want);
      reading_type predicted;
      while (!calm && $urandom_range(99) < 31) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= mode;
      req_tdata  <= {rev_cnt, fwd_cnt};
      do @(posedge clock); while (!req_tready);
      predicted = predict_word(mode, fwd_cnt, rev_cnt);
      expected_readings.push_back(typed ? want : predicted);
   endtask

   // stop sending until every pending response word has been taken
   task automatic drain_readings();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (expected_readings.size() != 0);
   endtask

   // one configuration setting followed by a random stream
   task automatic run_phase(input cfg_type s, input int count, input bit quiet);
      logic [REQ_USER_W-1:0] mode;
      logic [RAW_W-1:0]      fwd_cnt, rev_cnt;
      int                    pick;
      drain_readings();
      write_reg(CSR_VOLT_SCALE, s.volt_scale);
      write_reg(CSR_FWD_POWER_MAX, s.fwd_power_max);
      write_reg(CSR_REV_POWER_MAX, s.rev_power_max);
      write_reg(CSR_FWD_POWER_MIN, s.fwd_power_min);
      write_reg(CSR_REV_POWER_FLOOR, s.rev_power_floor);
      write_reg(CSR_VSWR_LIMIT, {16'($urandom), s.vswr_limit});
      write_reg(CSR_COOLDOWN_TICKS, {16'($urandom), s.cooldown_ticks});
      write_reg(CSR_SPARE, $urandom);
      csr_we <= 1'b0;
      calm = quiet;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(99);
         if (pick < 55)      mode = MODE_SAMPLE;
         else if (pick < 85) mode = MODE_TICK;
         else if (pick < 90) mode = MODE_RELEASE;
         else if (pick < 93) mode = MODE_DISARM;
         else if (pick < 98) mode = MODE_ARM;
         else                mode = 3'($urandom_range(MODE_UNUSED_LO, MODE_UNUSED_HI));
         draw_counts(fwd_cnt, rev_cnt);
         // now and then let the block run dry mid-stream
         if ($urandom_range(199) == 0) drain_readings();
         send_word(mode, fwd_cnt, rev_cnt, 1'b0, NO_READING);
      end
      calm = 1'b0;
   endtask

   function automatic cfg_type random_setting();
      cfg_type s;
      s.volt_scale      = $urandom_range(400000, 20000);
      s.fwd_power_max   = $urandom_range(32'hFFFF_FFFF, 32'h1000_0000);
      s.rev_power_max   = $urandom_range(32'h1000_0000, 32'h0040_0000);
      s.fwd_power_min   = $urandom_range(32'h0010_0000, 0);
      s.rev_power_floor = $urandom_range(32'h0100_0000, 0);
      s.vswr_limit      = 16'($urandom_range(1024, 256));
      s.cooldown_ticks  = 16'($urandom_range(6, 0));
      return s;
   endfunction

   // response side: random back-pressure, compare each word with the oldest prediction
   initial begin
      reading_type want, got;
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) begin
            got = '{rsp_tdata[31:0], rsp_tdata[63:32], rsp_tdata[79:64], rsp_tdata[80],
                    rsp_tdata[81], rsp_tdata[82], rsp_tuser};
            if (rsp_tdata[RSP_DATA_W-1:83] !== '0)
               note_mismatch($sformatf("pad bits nonzero: %h", rsp_tdata[RSP_DATA_W-1:83]));
            if (expected_readings.size() == 0) begin
               note_mismatch($sformatf("response word with nothing pending: %h", got));
            end else begin
               want = expected_readings.pop_front();
               if (got.fwd_power !== want.fwd_power)
                  note_mismatch($sformatf("fwd_power exp %h got %h",
                                          want.fwd_power, got.fwd_power));
               if (got.rev_power !== want.rev_power)
                  note_mismatch($sformatf("rev_power exp %h got %h",
                                          want.rev_power, got.rev_power));
               if (got.vswr_value !== want.vswr_value)
                  note_mismatch($sformatf("vswr_value exp %h got %h",
                                          want.vswr_value, got.vswr_value));
               if (got.key_enabled !== want.key_enabled)
                  note_mismatch($sformatf("key_enabled exp %b got %b",
                                          want.key_enabled, got.key_enabled));
               if (got.auto_release !== want.auto_release)
                  note_mismatch($sformatf("auto_release exp %b got %b",
                                          want.auto_release, got.auto_release));
               if (got.cooling !== want.cooling)
                  note_mismatch($sformatf("cooling exp %b got %b",
                                          want.cooling, got.cooling));
               if (got.evaluated !== want.evaluated)
                  note_mismatch($sformatf("evaluated exp %b got %b",
                                          want.evaluated, got.evaluated));
            end
         end
         rsp_tready <= calm || ($urandom_range(99) >= 31);
      end
   end

   // watchdog: too long without any handshake on either side
   initial begin
      while (stuck_cycles < STUCK_LIMIT) begin
         @(posedge clock);
         if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            stuck_cycles = 0;
         else
            stuck_cycles++;
      end
      $display("status: fail");
      $finish;
   end

   // main sequence
   initial begin
      plan_row_type directed_plan[$];
      cfg_type      s;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= MODE_SAMPLE;
      csr_we     <= 1'b0;
      csr_index  <= CSR_VOLT_SCALE;
      csr_wdata  <= '0;
      meter_cfg = '{RST_VOLT_SCALE, RST_FWD_POWER_MAX, RST_REV_POWER_MAX, RST_FWD_POWER_MIN,
                    RST_REV_POWER_FLOOR, RST_VSWR_LIMIT, RST_COOLDOWN_TICKS};
      key_on          = 1'b1;
      auto_release_on = 1'b1;
      cooldown_left   = '0;
      fwd_power_now   = '0;
      rev_power_now   = '0;
      vswr_now        = VSWR_ONE;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // short cooldown so the directed part can count it out
      write_reg(CSR_COOLDOWN_TICKS, 32'd3);
      csr_we <= 1'b0;

      // directed part: status after reset, unused modes, vswr corner cases, trips
      directed_plan.push_back('{MODE_TICK, 16'd0, 16'd0, 1'b1, AT_RESET});
      directed_plan.push_back('{MODE_UNUSED_LO, 16'hFFFF, 16'hFFFF, 1'b1, AT_RESET});
      directed_plan.push_back('{MODE_UNUSED_MID, 16'h5A5A, 16'hA5A5, 1'b1, AT_RESET});
      directed_plan.push_back('{MODE_UNUSED_HI, 16'h8000, 16'h7FFF, 1'b1, AT_RESET});
      directed_plan.push_back('{MODE_SAMPLE, 16'd0, 16'd0, 1'b1, ZERO_SAMPLE});
      directed_plan.push_back('{MODE_SAMPLE, 16'h7FFF, 16'd0, 1'b0, NO_READING});
      // equal counts: denominator zero
      directed_plan.push_back('{MODE_SAMPLE, 16'd1000, 16'd1000, 1'b0, NO_READING});
      // sum negative: vswr clamps to zero
      directed_plan.push_back('{MODE_SAMPLE, 16'd1000, -16'sd1200, 1'b0, NO_READING});
      // tiny forward power: vswr reads 1.0
      directed_plan.push_back('{MODE_SAMPLE, 16'd10, 16'd5, 1'b0, NO_READING});
      // reverse power over its limit trips and starts cooldown
      directed_plan.push_back('{MODE_SAMPLE, 16'd20000, 16'd19000, 1'b0, NO_READING});
      // sample while cooling is ignored
      directed_plan.push_back('{MODE_SAMPLE, 16'd100, 16'd0, 1'b0, NO_READING});
      directed_plan.push_back('{MODE_RELEASE, 16'd0, 16'd0, 1'b0, NO_READING});
      directed_plan.push_back('{MODE_TICK, 16'd0, 16'd0, 1'b0, NO_READING});
      directed_plan.push_back('{MODE_TICK, 16'd0, 16'd0, 1'b0, NO_READING});
      directed_plan.push_back('{MODE_TICK, 16'd0, 16'd0, 1'b0, NO_READING});
      // vswr over its limit with reverse power above the floor
      directed_plan.push_back('{MODE_SAMPLE, 16'd3000, 16'd2000, 1'b0, NO_READING});
      directed_plan.push_back('{MODE_DISARM, 16'd0, 16'd0, 1'b0, NO_READING});
      directed_plan.push_back('{MODE_TICK, 16'd0, 16'd0, 1'b0, NO_READING});
      directed_plan.push_back('{MODE_TICK, 16'd0, 16'd0, 1'b0, NO_READING});
      directed_plan.push_back('{MODE_TICK, 16'd0, 16'd0, 1'b0, NO_READING});
      // clean sample with auto-release off keeps the key off
      directed_plan.push_back('{MODE_SAMPLE, 16'd100, 16'd0, 1'b0, NO_READING});
      directed_plan.push_back('{MODE_ARM, 16'd0, 16'd0, 1'b0, NO_READING});
      directed_plan.push_back('{MODE_SAMPLE, 16'd100, 16'd0, 1'b0, NO_READING});
      directed_plan.push_back('{MODE_SAMPLE, 16'h8000, 16'h7FFF, 1'b0, NO_READING});
      directed_plan.push_back('{MODE_RELEASE, 16'd0, 16'd0, 1'b0, NO_READING});
      foreach (directed_plan[i])
         send_word(directed_plan[i].mode, directed_plan[i].fwd_cnt, directed_plan[i].rev_cnt,
                   directed_plan[i].typed, directed_plan[i].want);

      // defaults with a short cooldown
      s = '{RST_VOLT_SCALE, RST_FWD_POWER_MAX, RST_REV_POWER_MAX, RST_FWD_POWER_MIN,
            RST_REV_POWER_FLOOR, RST_VSWR_LIMIT, 16'd5};
      run_phase(s, 190, 1'b0);
      // full scale and open limits, zero thresholds, no idling on either side
      s = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0, 32'd0, 16'd0, 16'd0};
      run_phase(s, 180, 1'b1);
      // zero scale: nothing measurable
      s = '{32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 16'hFFFF, 16'd1};
      run_phase(s, 150, 1'b0);
      run_phase(random_setting(), 190, 1'b0);
      run_phase(random_setting(), 190, 1'b0);
      // longest cooldown last, once tripped it outlasts the run
      s = random_setting();
      s.cooldown_ticks = 16'hFFFF;
      run_phase(s, 200, 1'b0);

      drain_readings();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (expected_readings.size() != 0) mismatches++;
      if (mismatches == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
